/* rtl/csp_pkg.sv */
// Shared types, register codes and constants for the colour spill suppressor.
// No dependencies; the stage modules, the top level and the testbench import this package.
`default_nettype none

package csp_pkg;

	localparam int CFG_DW = 13;

	// Fixed-point layout: signed Q3.12 pixels, unsigned Q1.12 gains
	localparam int FRAC      = 12;
	localparam int DIFF_SH   = FRAC + 1;
	localparam int ROUND_Q12 = 1 << (FRAC - 1);
	localparam int ONE_Q12   = 1 << FRAC;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic [2:0] REG_LIMIT_MODE     = 3'd0;
	localparam logic [2:0] REG_KEY_CHANNEL    = 3'd1;
	localparam logic [2:0] REG_LIMIT_CHANNEL  = 3'd2;
	localparam logic [2:0] REG_LIMIT_SCALE    = 3'd3;
	localparam logic [2:0] REG_UNSPILL_ENABLE = 3'd4;
	localparam logic [2:0] REG_GAIN_RED       = 3'd5;
	localparam logic [2:0] REG_GAIN_GREEN     = 3'd6;
	localparam logic [2:0] REG_GAIN_BLUE      = 3'd7;

	typedef struct packed {
		logic              limit_mode;
		logic [1:0]        key_channel;
		logic [1:0]        limit_channel;
		logic [CFG_DW-1:0] limit_scale;
		logic              unspill_enable;
		logic [CFG_DW-1:0] gain_red;
		logic [CFG_DW-1:0] gain_green;
		logic [CFG_DW-1:0] gain_blue;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		limit_mode:     1'b0,
		key_channel:    CH_GREEN,
		limit_channel:  CH_RED,
		limit_scale:    CFG_DW'(ONE_Q12),
		unspill_enable: 1'b0,
		gain_red:       '0,
		gain_green:     CFG_DW'(ONE_Q12),
		gain_blue:      '0
	};

	// Channel selector: the unused code acts as blue
	function automatic logic [1:0] sel_ch(input logic [1:0] s);
		return (s >= CH_BLUE) ? CH_BLUE : s;
	endfunction

	// Width of the capped factor: wide enough to hold 1.0
	function automatic int fac_w(input int p);
		return (p > FRAC + 1) ? p : FRAC + 2;
	endfunction

endpackage

`default_nettype wire

/* rtl/csp_if.sv */
// Request channels of the spill suppressor: pixel in, despilled pixel out.
// Depends on nothing; widths follow the pixel width parameter.
`default_nettype none

interface csp_pix_if #(parameter int PIXEL_WIDTH = 16);
	logic                   valid;
	logic                   ready;
	logic [PIXEL_WIDTH-1:0] in_red;
	logic [PIXEL_WIDTH-1:0] in_green;
	logic [PIXEL_WIDTH-1:0] in_blue;
	logic [PIXEL_WIDTH-1:0] in_alpha;
	logic [PIXEL_WIDTH-1:0] in_factor;

	modport source (output valid, in_red, in_green, in_blue, in_alpha, in_factor,
		input ready);
	modport sink (input valid, in_red, in_green, in_blue, in_alpha, in_factor,
		output ready);
endinterface

interface csp_res_if #(parameter int PIXEL_WIDTH = 16);
	logic                   valid;
	logic                   ready;
	logic [PIXEL_WIDTH-1:0] out_red;
	logic [PIXEL_WIDTH-1:0] out_green;
	logic [PIXEL_WIDTH-1:0] out_blue;
	logic [PIXEL_WIDTH-1:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha,
		output ready);
endinterface

`default_nettype wire

/* rtl/csp_limit.sv */
// Stages 1 and 2: channel selection, factor cap and the scaled spill difference.
// Depends on csp_pkg.
`default_nettype none

module csp_limit import csp_pkg::*; #(
	parameter int PIXEL_WIDTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire cfg_t                                      cfg,
	input  wire logic                                      in_valid,
	output      logic                                      in_ready,
	input  wire logic [3:0][PIXEL_WIDTH-1:0]               in_px,
	input  wire logic [PIXEL_WIDTH-1:0]                    in_factor,
	output      logic                                      out_valid,
	input  wire logic                                      out_ready,
	output      logic [3:0][PIXEL_WIDTH-1:0]               out_px,
	output      logic signed [fac_w(PIXEL_WIDTH)-1:0]      out_rfac,
	output      logic signed [PIXEL_WIDTH+DIFF_SH+1:0]     out_diff
);

	localparam int FW = fac_w(PIXEL_WIDTH);
	localparam int TW = PIXEL_WIDTH + 1;
	localparam int DW = PIXEL_WIDTH + DIFF_SH + 2;
	localparam logic signed [FW-1:0] ONE_F = FW'(ONE_Q12);

	logic v_s1, v_s2, en_s1, en_s2;
	logic [1:0] sc, lc, c2i, c3i;
	logic signed [FW-1:0] fac_x;
	logic signed [TW-1:0] term_c;

	logic [3:0][PIXEL_WIDTH-1:0] px_s1, px_s2;
	logic signed [PIXEL_WIDTH-1:0] spill_s1;
	logic signed [TW-1:0] term_s1;
	logic signed [FW-1:0] rfac_s1, rfac_s2;
	logic signed [DW-1:0] prod_c, diff_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		sc    = sel_ch(cfg.key_channel);
		lc    = sel_ch(cfg.limit_channel);
		c2i   = (sc == CH_RED) ? CH_GREEN : CH_RED;
		c3i   = (sc == CH_BLUE) ? CH_GREEN : CH_BLUE;
		fac_x = FW'($signed(in_factor));
		if (cfg.limit_mode) begin
			term_c = TW'($signed(in_px[c2i])) + TW'($signed(in_px[c3i]));
		end else begin
			term_c = TW'($signed(in_px[lc])) <<< 1;
		end
	end

	assign prod_c = $signed({1'b0, cfg.limit_scale}) * term_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1    <= in_px;
			spill_s1 <= $signed(in_px[sc]);
			term_s1  <= term_c;
			rfac_s1  <= (fac_x > ONE_F) ? ONE_F : fac_x;
		end
		if (en_s2) begin
			px_s2   <= px_s1;
			rfac_s2 <= rfac_s1;
			diff_s2 <= (DW'(spill_s1) <<< DIFF_SH) - prod_c;
		end
	end

	assign out_valid = v_s2;
	assign out_px    = px_s2;
	assign out_rfac  = rfac_s2;
	assign out_diff  = diff_s2;

endmodule

`default_nettype wire

/* rtl/csp_map.sv */
// Stages 3 and 4: round the difference, multiply by the factor, cap the amount.
// Depends on csp_pkg.
`default_nettype none

module csp_map import csp_pkg::*; #(
	parameter int PIXEL_WIDTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output      logic                                  in_ready,
	input  wire logic [3:0][PIXEL_WIDTH-1:0]           in_px,
	input  wire logic signed [fac_w(PIXEL_WIDTH)-1:0]  in_rfac,
	input  wire logic signed [PIXEL_WIDTH+DIFF_SH+1:0] in_diff,
	output      logic                                  out_valid,
	input  wire logic                                  out_ready,
	output      logic [3:0][PIXEL_WIDTH-1:0]           out_px,
	output      logic [PIXEL_WIDTH+13:0]               out_map,
	output      logic                                  out_apply
);

	localparam int FW  = fac_w(PIXEL_WIDTH);
	localparam int DW  = PIXEL_WIDTH + DIFF_SH + 2;
	localparam int DDW = DW - DIFF_SH;
	localparam int XW  = FW + DDW + 1;
	localparam int MW  = PIXEL_WIDTH + 14;
	localparam int MXW = (XW > MW) ? XW : MW;
	localparam logic signed [DW-1:0] RND_D = DW'(1) <<< (DIFF_SH - 1);
	localparam logic [MXW-1:0] CAP = MXW'({1'b1, {(MW-1){1'b0}}});

	logic v_s3, v_s4, en_s3, en_s4;
	logic signed [DW-1:0]  t_c;
	logic signed [DDW-1:0] d_c;
	logic [XW-1:0]  sum_c;
	logic [MXW-1:0] mapr_c;

	logic [3:0][PIXEL_WIDTH-1:0] px_s3, px_s4;
	logic [FW-1:0]  ma_s3;
	logic [DDW-1:0] mb_s3;
	logic           ok_s3, apply_s4;
	logic [MW-1:0]  map_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	assign t_c    = in_diff + RND_D;
	assign d_c    = $signed(t_c[DW-1:DIFF_SH]);
	assign sum_c  = XW'(ma_s3) * XW'(mb_s3) + XW'(ROUND_Q12);
	assign mapr_c = MXW'(sum_c >> FRAC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			px_s3 <= in_px;
			ma_s3 <= (in_rfac < 0) ? FW'(-in_rfac) : FW'(in_rfac);
			mb_s3 <= (d_c < 0) ? DDW'(-d_c) : DDW'(d_c);
			ok_s3 <= (in_rfac > 0 && d_c > 0) || (in_rfac < 0 && d_c < 0);
		end
		if (en_s4) begin
			px_s4    <= px_s3;
			map_s4   <= (mapr_c > CAP) ? CAP[MW-1:0] : mapr_c[MW-1:0];
			apply_s4 <= ok_s3 && (mapr_c != '0);
		end
	end

	assign out_valid = v_s4;
	assign out_px    = px_s4;
	assign out_map   = map_s4;
	assign out_apply = apply_s4;

endmodule

`default_nettype wire

/* rtl/csp_apply.sv */
// Stages 5 and 6: per-channel gain, signed correction and saturation.
// Depends on csp_pkg.
`default_nettype none

module csp_apply import csp_pkg::*; #(
	parameter int PIXEL_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire cfg_t                        cfg,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [3:0][PIXEL_WIDTH-1:0] in_px,
	input  wire logic [PIXEL_WIDTH+13:0]     in_map,
	input  wire logic                        in_apply,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [3:0][PIXEL_WIDTH-1:0] out_px
);

	localparam int MW  = PIXEL_WIDTH + 14;
	localparam int GW  = CFG_DW + MW;
	localparam int DLW = GW - FRAC;
	localparam int RW  = PIXEL_WIDTH + 17;
	localparam logic signed [RW-1:0] HI = {{(RW-PIXEL_WIDTH+1){1'b0}}, {(PIXEL_WIDTH-1){1'b1}}};
	localparam logic signed [RW-1:0] LO = {{(RW-PIXEL_WIDTH+1){1'b1}}, {(PIXEL_WIDTH-1){1'b0}}};

	logic v_s5, v_s6, en_s5, en_s6;
	logic [1:0] sc;
	logic [2:0][CFG_DW-1:0] gain_c;
	logic [2:0][GW-1:0]     sum_c;
	logic signed [RW-1:0]   res_c [3];

	logic [3:0][PIXEL_WIDTH-1:0] px_s5, px_s6;
	logic [DLW-1:0] delta_s5 [3];

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;
	assign sc       = sel_ch(cfg.key_channel);

	always_comb begin
		gain_c = '{cfg.gain_blue, cfg.gain_green, cfg.gain_red};
		for (int i = 0; i < 3; i++) begin
			if (!cfg.unspill_enable) begin
				gain_c[i] = (2'(i) == sc) ? CFG_DW'(ONE_Q12) : '0;
			end
			sum_c[i] = GW'(gain_c[i]) * GW'(in_map) + GW'(ROUND_Q12);
			if (2'(i) == sc) begin
				res_c[i] = RW'($signed(px_s5[i])) - $signed(RW'(delta_s5[i]));
			end else begin
				res_c[i] = RW'($signed(px_s5[i])) + $signed(RW'(delta_s5[i]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			px_s5 <= in_px;
			for (int i = 0; i < 3; i++) begin
				delta_s5[i] <= in_apply ? sum_c[i][GW-1:FRAC] : '0;
			end
		end
		if (en_s6) begin
			px_s6[3] <= px_s5[3];
			for (int i = 0; i < 3; i++) begin
				if (res_c[i] > HI) begin
					px_s6[i] <= HI[PIXEL_WIDTH-1:0];
				end else if (res_c[i] < LO) begin
					px_s6[i] <= LO[PIXEL_WIDTH-1:0];
				end else begin
					px_s6[i] <= res_c[i][PIXEL_WIDTH-1:0];
				end
			end
		end
	end

	assign out_valid = v_s6;
	assign out_px    = px_s6;

	// unit gain mode touches the spill channel alone
	a_unit_gain_spill_only: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !cfg.unspill_enable) |->
			((sc == CH_RED) || (delta_s5[0] == '0)) &&
			((sc == CH_GREEN) || (delta_s5[1] == '0)) &&
			((sc == CH_BLUE) || (delta_s5[2] == '0)))
		else $error("correction on a non-spill channel with unspill off");

endmodule

`default_nettype wire

/* rtl/color_spill_suppress_top.sv */
// Top level of the colour spill suppressor: register file and six-stage pipeline.
// Depends on csp_pkg, csp_if, csp_limit, csp_map and csp_apply.
//
// Usage:
//   pix carries one request per pixel: red, green, blue, alpha and the matte
//   factor, all signed Q3.12. res returns the despilled pixel with alpha copied.
//   Each request yields exactly one result, in order.
//   Throughput is one pixel per clock while res is ready, set by the six
//   register stages (select, difference multiply, round, factor multiply,
//   gain multiply, saturate) each of which holds one pixel.
//   Every stage has its own valid bit and advances when it is empty or when the
//   stage after it moves, so bubbles close up. When res stalls, the pipeline
//   keeps filling; pix.ready drops only once all six stages hold pixels, and
//   nothing is lost or repeated.
//   wr_en/wr_index/wr_data write one control register per clock; write only
//   while the pipeline is empty.
//   arst_n clears all valid bits and returns the registers to their defaults
//   (green spill, simple limit on red, unit limit scale, unspill off).
`default_nettype none

module color_spill_suppress_top import csp_pkg::*; #(
	parameter int PIXEL_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	csp_pix_if.sink                pix,
	csp_res_if.source              res,
	input  wire logic              wr_en,
	input  wire logic [2:0]        wr_index,
	input  wire logic [CFG_DW-1:0] wr_data
);

	localparam int FW = fac_w(PIXEL_WIDTH);
	localparam int DW = PIXEL_WIDTH + DIFF_SH + 2;
	localparam int MW = PIXEL_WIDTH + 14;

	cfg_t cfg_q;

	logic [3:0][PIXEL_WIDTH-1:0] px_in, px_a, px_b, px_out;
	logic                        v_a, r_a, v_b, r_b;
	logic signed [FW-1:0]        rfac_a;
	logic signed [DW-1:0]        diff_a;
	logic [MW-1:0]               map_b;
	logic                        apply_b;

	// Control registers: hold until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LIMIT_MODE:     cfg_q.limit_mode     <= wr_data[0];
				REG_KEY_CHANNEL:    cfg_q.key_channel    <= wr_data[1:0];
				REG_LIMIT_CHANNEL:  cfg_q.limit_channel  <= wr_data[1:0];
				REG_LIMIT_SCALE:    cfg_q.limit_scale    <= wr_data;
				REG_UNSPILL_ENABLE: cfg_q.unspill_enable <= wr_data[0];
				REG_GAIN_RED:       cfg_q.gain_red       <= wr_data;
				REG_GAIN_GREEN:     cfg_q.gain_green     <= wr_data;
				REG_GAIN_BLUE:      cfg_q.gain_blue      <= wr_data;
			endcase
		end
	end

	// Pack the request so that channels can be picked by index
	assign px_in = {pix.in_alpha, pix.in_blue, pix.in_green, pix.in_red};

	// Stages 1-2: pick spill and limit channels, cap the factor, form the difference
	csp_limit #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_limit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.in_px     (px_in),
		.in_factor (pix.in_factor),
		.out_valid (v_a),
		.out_ready (r_a),
		.out_px    (px_a),
		.out_rfac  (rfac_a),
		.out_diff  (diff_a)
	);

	// Stages 3-4: spill amount, kept only where it comes out positive
	csp_map #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_a),
		.in_ready  (r_a),
		.in_px     (px_a),
		.in_rfac   (rfac_a),
		.in_diff   (diff_a),
		.out_valid (v_b),
		.out_ready (r_b),
		.out_px    (px_b),
		.out_map   (map_b),
		.out_apply (apply_b)
	);

	// Stages 5-6: scale by gain, subtract on the spill channel, add elsewhere
	csp_apply #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_apply (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v_b),
		.in_ready  (r_b),
		.in_px     (px_b),
		.in_map    (map_b),
		.in_apply  (apply_b),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_px    (px_out)
	);

	assign res.out_red   = px_out[0];
	assign res.out_green = px_out[1];
	assign res.out_blue  = px_out[2];
	assign res.out_alpha = px_out[3];

	// With the last stage free, every stage can advance, so a request is taken
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!res.valid || res.ready) |-> pix.ready)
		else $error("pixel refused while the output stage is free");

	// Reset leaves nothing in flight
	a_empty_after_reset: assert property (@(posedge clk)
		!arst_n |=> !res.valid)
		else $error("result presented straight after reset");

endmodule

`default_nettype wire

/* test/color_spill_suppress_top_test.sv */
// Self-checking testbench for color_spill_suppress_top: streams pixels through
// random stalls on both channels and checks each result against a despill predictor.
// Depends on csp_pkg, csp_if and the RTL of the block.
`default_nettype none

module color_spill_suppress_top_test;
	import csp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW          = 16;
	localparam int PIPE_DEPTH  = 6;
	localparam int SETTLE      = PIPE_DEPTH + 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BLOCKS      = 9;
	localparam int BLOCK_ITEMS = 50;

	localparam longint PIX_MAX = (longint'(1) << (PW - 1)) - 1;
	localparam longint PIX_MIN = -(longint'(1) << (PW - 1));
	localparam longint MAP_CAP = longint'(1) << (PW + 13);

	typedef struct packed {
		logic [PW-1:0] red;
		logic [PW-1:0] green;
		logic [PW-1:0] blue;
		logic [PW-1:0] alpha;
		logic [PW-1:0] factor;
	} pixel_t;

	typedef struct packed {
		logic [PW-1:0] red;
		logic [PW-1:0] green;
		logic [PW-1:0] blue;
		logic [PW-1:0] alpha;
	} rgba_t;

	// Scoreboard: a private copy of the control registers, the despill
	// predictor and the queue of pixels still owed by the block.
	class despill_board;
		cfg_t  regs;
		rgba_t owed_pixels [$];
		int    fails;

		function new();
			regs  = CFG_RST;
			fails = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [CFG_DW-1:0] val);
			case (idx)
				REG_LIMIT_MODE:     regs.limit_mode     = val[0];
				REG_KEY_CHANNEL:    regs.key_channel    = val[1:0];
				REG_LIMIT_CHANNEL:  regs.limit_channel  = val[1:0];
				REG_LIMIT_SCALE:    regs.limit_scale    = val;
				REG_UNSPILL_ENABLE: regs.unspill_enable = val[0];
				REG_GAIN_RED:       regs.gain_red       = val;
				REG_GAIN_GREEN:     regs.gain_green     = val;
				REG_GAIN_BLUE:      regs.gain_blue      = val;
				default: ;
			endcase
		endfunction

		function rgba_t despill(pixel_t p);
			longint c [3];
			longint gain [3];
			longint outv [3];
			longint fac, diff, d, amount, delta;
			int sc, lc, o1, o2;
			bit apply;
			rgba_t r;
			c[0] = longint'($signed(p.red));
			c[1] = longint'($signed(p.green));
			c[2] = longint'($signed(p.blue));
			fac  = longint'($signed(p.factor));
			if (fac > ONE_Q12) fac = ONE_Q12;
			// selector code three behaves as blue
			sc = (regs.key_channel >= CH_BLUE) ? 2 : int'(regs.key_channel);
			lc = (regs.limit_channel >= CH_BLUE) ? 2 : int'(regs.limit_channel);
			o1 = (sc == 0) ? 1 : 0;
			o2 = (sc == 2) ? 1 : 2;
			if (regs.limit_mode == 1'b0) begin
				diff = c[sc] * 8192 - longint'(regs.limit_scale) * 2 * c[lc];
			end else begin
				diff = c[sc] * 8192 - longint'(regs.limit_scale) * (c[o1] + c[o2]);
			end
			d = (diff + 4096) >>> 13;
			amount = 0;
			if ((fac > 0 && d > 0) || (fac < 0 && d < 0)) begin
				amount = ((fac < 0 ? -fac : fac) * (d < 0 ? -d : d) + 2048) >>> 12;
				if (amount > MAP_CAP) amount = MAP_CAP;
			end
			apply = (amount > 0);
			if (regs.unspill_enable) begin
				gain[0] = longint'(regs.gain_red);
				gain[1] = longint'(regs.gain_green);
				gain[2] = longint'(regs.gain_blue);
			end else begin
				gain[0] = 0;
				gain[1] = 0;
				gain[2] = 0;
				gain[sc] = ONE_Q12;
			end
			for (int i = 0; i < 3; i++) begin
				outv[i] = c[i];
				if (apply) begin
					delta = (gain[i] * amount + 2048) >>> 12;
					outv[i] = (i == sc) ? c[i] - delta : c[i] + delta;
				end
				if (outv[i] > PIX_MAX) outv[i] = PIX_MAX;
				if (outv[i] < PIX_MIN) outv[i] = PIX_MIN;
			end
			r.red   = PW'(outv[0]);
			r.green = PW'(outv[1]);
			r.blue  = PW'(outv[2]);
			r.alpha = p.alpha;
			return r;
		endfunction

		function void note_pixel(pixel_t p);
			owed_pixels.push_back(despill(p));
		endfunction

		function void check_result(rgba_t got);
			rgba_t want;
			if (owed_pixels.size() == 0) begin
				$error("unexpected result: red %0d green %0d blue %0d alpha %0d",
					$signed(got.red), $signed(got.green), $signed(got.blue),
					$signed(got.alpha));
				fails++;
				return;
			end
			want = owed_pixels.pop_front();
			if (got.red !== want.red) begin
				$error("out_red: expected %0d, actual %0d", $signed(want.red), $signed(got.red));
				fails++;
			end
			if (got.green !== want.green) begin
				$error("out_green: expected %0d, actual %0d",
					$signed(want.green), $signed(got.green));
				fails++;
			end
			if (got.blue !== want.blue) begin
				$error("out_blue: expected %0d, actual %0d",
					$signed(want.blue), $signed(got.blue));
				fails++;
			end
			if (got.alpha !== want.alpha) begin
				$error("out_alpha: expected %0d, actual %0d",
					$signed(want.alpha), $signed(got.alpha));
				fails++;
			end
		endfunction

		function int pending();
			return owed_pixels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [CFG_DW-1:0] wr_data;

	int send_idle = 0;
	int recv_idle = 0;
	int cycles = 0;

	despill_board board = new();

	csp_pix_if #(.PIXEL_WIDTH(PW)) pix ();
	csp_res_if #(.PIXEL_WIDTH(PW)) res ();

	color_spill_suppress_top #(.PIXEL_WIDTH(PW)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.res      (res),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Write one control register; the caller drops wr_en after the last one.
	// The scoreboard copy is updated at once: the pipeline is empty here.
	task automatic load_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		board.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic load_settings(input cfg_t s);
		load_reg(REG_LIMIT_MODE,     CFG_DW'(s.limit_mode));
		load_reg(REG_KEY_CHANNEL,    CFG_DW'(s.key_channel));
		load_reg(REG_LIMIT_CHANNEL,  CFG_DW'(s.limit_channel));
		load_reg(REG_LIMIT_SCALE,    s.limit_scale);
		load_reg(REG_UNSPILL_ENABLE, CFG_DW'(s.unspill_enable));
		load_reg(REG_GAIN_RED,       s.gain_red);
		load_reg(REG_GAIN_GREEN,     s.gain_green);
		load_reg(REG_GAIN_BLUE,      s.gain_blue);
		wr_en <= 1'b0;
	endtask

	// Offer one pixel request, idling first at the current sender rate.
	// Valid stays high on return so back-to-back requests need no extra edge;
	// only the idle loop and drain lower it, and never in the step that raises it.
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid     <= 1'b1;
		pix.in_red    <= p.red;
		pix.in_green  <= p.green;
		pix.in_blue   <= p.blue;
		pix.in_alpha  <= p.alpha;
		pix.in_factor <= p.factor;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		board.note_pixel(p);
	endtask

	// Drop valid, then hold until every owed pixel has come back and the
	// pipeline has had time to empty, so registers can be rewritten safely.
	task automatic drain();
		pix.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Gains and scales: favour zero, unity and full scale, else anything.
	function automatic logic [CFG_DW-1:0] pick_q12();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return CFG_DW'(ONE_Q12);
			default: return CFG_DW'($urandom);
		endcase
	endfunction

	function automatic cfg_t random_settings();
		cfg_t s;
		s.limit_mode     = 1'($urandom_range(1));
		s.key_channel    = 2'($urandom_range(3));
		s.limit_channel  = 2'($urandom_range(3));
		s.limit_scale    = pick_q12();
		s.unspill_enable = 1'($urandom_range(1));
		s.gain_red       = pick_q12();
		s.gain_green     = pick_q12();
		s.gain_blue      = pick_q12();
		return s;
	endfunction

	// A quarter of the pixels are raw noise over the full range, which
	// toggles every bit; the rest look like keyed footage with a factor
	// mostly inside 0..1 so that the correction is applied without saturating.
	function automatic pixel_t random_pixel();
		pixel_t p;
		if ($urandom_range(3) == 0) begin
			p = pixel_t'({$urandom, $urandom, PW'($urandom)});
		end else begin
			p.red    = PW'($urandom_range(6000));
			p.green  = PW'($urandom_range(6000));
			p.blue   = PW'($urandom_range(6000));
			p.alpha  = PW'($urandom);
			p.factor = PW'(int'($urandom_range(4600)) - 300);
		end
		return p;
	endfunction

	// Edge pixels: zero input, unit spill, the factor cap, opposite extremes
	// that saturate both ways, both-negative spill, an amount that rounds to
	// nothing, zero and negative factors against positive spill.
	pixel_t edge_pixels [12] = '{
		'{16'sd0,      16'sd0,      16'sd0,      16'sd0,      16'sd0},
		'{16'sd0,      16'sd4096,   16'sd0,      16'sd4096,   16'sd4096},
		'{16'sd0,      16'sd32767,  16'sd0,      16'sd32767,  16'sd32767},
		'{-16'sd32768, 16'sd32767,  -16'sd32768, -16'sd32768, 16'sd4096},
		'{16'sd32767,  -16'sd32768, 16'sd32767,  16'sd0,      -16'sd32768},
		'{16'sd100,    16'sd101,    16'sd0,      16'sd0,      16'sd1},
		'{16'sd0,      16'sd2048,   16'sd0,      16'sd0,      16'sd2048},
		'{16'sd4096,   16'sd4096,   16'sd4096,   16'sd4096,   16'sd4096},
		'{16'sd0,      16'sd4096,   16'sd0,      -16'sd1,     -16'sd1},
		'{16'sd1000,   16'sd3000,   16'sd2000,   16'sd1234,   16'sd0},
		'{-16'sd1,     -16'sd1,     -16'sd1,     -16'sd1,     -16'sd1},
		'{16'sd0,      -16'sd4096,  16'sd0,      16'sd0,      -16'sd4096}
	};

	// Result side: check what was taken at this edge, then pick the next
	// ready level at the current receiver rate.
	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				board.check_result(rgba_t'{res.out_red, res.out_green, res.out_blue,
					res.out_alpha});
			end
			res.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		cfg_t top_cfg;
		cfg_t zero_cfg;
		arst_n        <= 1'b0;
		wr_en         <= 1'b0;
		wr_index      <= REG_LIMIT_MODE;
		wr_data       <= '0;
		pix.valid     <= 1'b0;
		pix.in_red    <= '0;
		pix.in_green  <= '0;
		pix.in_blue   <= '0;
		pix.in_alpha  <= '0;
		pix.in_factor <= '0;

		// Every field at its top code: average mode, selector code three
		// on both channels, full limit scale, unspill on, full gains.
		top_cfg = '1;
		zero_cfg = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass under the reset settings: simple limit on red, green spill
		send_idle = 16;
		recv_idle = 85;
		foreach (edge_pixels[i]) send_pixel(edge_pixels[i]);
		drain();

		// Same pixels with everything at its top code
		load_settings(top_cfg);
		foreach (edge_pixels[i]) send_pixel(edge_pixels[i]);
		drain();

		// Random blocks: slow receiver first, then slow sender, then full rate.
		// The first block runs with every register at zero.
		for (int blk = 0; blk < BLOCKS; blk++) begin
			case (blk / 3)
				0: begin
					send_idle = 16;
					recv_idle = 85;
				end
				1: begin
					send_idle = 85;
					recv_idle = 16;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			load_settings(blk == 0 ? zero_cfg : random_settings());
			repeat (BLOCK_ITEMS) send_pixel(random_pixel());
			drain();
		end

		if (board.fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
